// ----- design/srec_s3_record_loader_core_macros.svh -----
// ----------------------------------------------------------------------------
// srec s3 record loader assertion macros
// shared property wrappers for the loader core
// ----------------------------------------------------------------------------
`ifndef SREC_S3_RECORD_LOADER_CORE_MACROS_SVH
`define SREC_S3_RECORD_LOADER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define SREC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet in reset
`define SREC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/srec_pkg.sv -----
// ----------------------------------------------------------------------------
// srec loader package
// parse phase and result codes, parser state type, hex digit decode
// ----------------------------------------------------------------------------
package srec_pkg;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_COUNT = 3'd2;
  localparam logic [2:0] PH_ADDR  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_SKIP  = 3'd5;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_FINISHED = 2'd1;
  localparam logic [1:0] KIND_STOPPED  = 2'd2;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] HEX_GAP   = 8'd7;
  localparam logic [7:0] HDR_BYTES = 8'd5;

  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  byte_count;
    logic [31:0] rec_addr;
    logic [31:0] offset;      // record address plus data index
    logic [3:0]  hold;
    logic [3:0]  digit_pos;
    logic [7:0]  data_index;
    logic        done;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] offset;
    logic [7:0]  data;
  } parse_result_t;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = c - CH_ZERO;
    if (v > 8'd9) begin
      v = v - HEX_GAP;
    end
    return v[3:0];
  endfunction

endpackage

// ----- design/srec_step.sv -----
// ----------------------------------------------------------------------------
// srec loader step
// next parser state and optional result for one character
// ----------------------------------------------------------------------------
module srec_step (
  input  srec_pkg::parse_state_t  st,
  input  logic [7:0]              ch,
  output srec_pkg::parse_state_t  st_next,
  output logic                    res_valid,
  output srec_pkg::parse_result_t res
);

  logic [3:0] nib;
  logic [7:0] data_total;
  logic [8:0] index_inc;
  logic [7:0] count_next;
  logic [7:0] total_next;

  assign nib        = srec_pkg::nibble_of(ch);
  assign data_total = (st.byte_count >= srec_pkg::HDR_BYTES) ?
                      (st.byte_count - srec_pkg::HDR_BYTES) : 8'd0;
  assign index_inc  = {1'b0, st.data_index} + 9'd1;
  assign count_next = st.byte_count;
  assign total_next = data_total;

  always_comb begin
    st_next   = st;
    res_valid = 1'b0;
    res       = '0;
    if (st.done) begin
      // ignore everything until reset
    end else if (st.phase == srec_pkg::PH_START) begin
      if (ch != srec_pkg::CH_S) begin
        st_next.done = 1'b1;
        res_valid    = 1'b1;
        res.kind     = srec_pkg::KIND_STOPPED;
      end else begin
        st_next.phase = srec_pkg::PH_TYPE;
      end
    end else if (ch == srec_pkg::CH_LF) begin
      st_next.phase     = srec_pkg::PH_START;
      st_next.digit_pos = 4'd0;
    end else begin
      case (st.phase)
        srec_pkg::PH_TYPE: begin
          if (ch == srec_pkg::CH_SEVEN || ch == srec_pkg::CH_EIGHT ||
              ch == srec_pkg::CH_NINE) begin
            st_next.done = 1'b1;
            res_valid    = 1'b1;
            res.kind     = srec_pkg::KIND_FINISHED;
          end else if (ch == srec_pkg::CH_THREE) begin
            st_next.phase      = srec_pkg::PH_COUNT;
            st_next.digit_pos  = 4'd0;
            st_next.byte_count = 8'd0;
            st_next.rec_addr   = 32'd0;
            st_next.data_index = 8'd0;
          end else begin
            st_next.phase = srec_pkg::PH_SKIP;
          end
        end
        srec_pkg::PH_COUNT: begin
          st_next.byte_count = {count_next[3:0], nib};
          if (st.digit_pos >= 4'd1) begin
            st_next.digit_pos = 4'd0;
            st_next.phase     = srec_pkg::PH_ADDR;
          end else begin
            st_next.digit_pos = st.digit_pos + 4'd1;
          end
        end
        srec_pkg::PH_ADDR: begin
          st_next.rec_addr = {st.rec_addr[27:0], nib};
          if (st.digit_pos >= 4'd7) begin
            st_next.digit_pos  = 4'd0;
            st_next.data_index = 8'd0;
            st_next.offset     = {st.rec_addr[27:0], nib};
            st_next.phase      = (total_next == 8'd0) ? srec_pkg::PH_SKIP
                                                      : srec_pkg::PH_DATA;
          end else begin
            st_next.digit_pos = st.digit_pos + 4'd1;
          end
        end
        srec_pkg::PH_DATA: begin
          if (st.digit_pos == 4'd0) begin
            st_next.hold      = nib;
            st_next.digit_pos = 4'd1;
          end else begin
            res_valid          = 1'b1;
            res.kind           = srec_pkg::KIND_DATA;
            res.offset         = st.offset;
            res.data           = {st.hold, nib};
            st_next.digit_pos  = 4'd0;
            st_next.data_index = index_inc[7:0];
            st_next.offset     = st.offset + 32'd1;
            if (index_inc >= {1'b0, data_total}) begin
              st_next.phase = srec_pkg::PH_SKIP;
            end
          end
        end
        default: begin
          st_next.phase = srec_pkg::PH_SKIP;
        end
      endcase
    end
  end

endmodule

// ----- design/srec_s3_record_loader_core.sv -----
// ----------------------------------------------------------------------------
// srec s3 record loader core
// parses s-record text one character per item, emits s3 data byte writes and finished or stopped reports
// ----------------------------------------------------------------------------
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------
// in       | in_valid / in_stall    | in_char
// out      | out_valid / out_stall  | out_kind, wr_addr, wr_data
// cfg      | cfg_valid / cfg_ready  | cfg_data (dest_base)
//
// one character item per cycle sustained while out_stall is low
// an accepted item passes the input register, the parser, then the result register
// out_stall holds the result register and backs up into in_stall
// rst (synchronous) clears parser state and dest_base, no clearing pass
// cfg_ready is always high
// ----------------------------------------------------------------------------
`include "srec_s3_record_loader_core_macros.svh"

module srec_s3_record_loader_core #(
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [ADDR_WIDTH-1:0] wr_addr,
  output logic [7:0]            wr_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data
);

  logic [31:0]             dest_base;
  logic                    s1_valid;
  logic [7:0]              s1_char;
  logic                    s1_adv;
  srec_pkg::parse_state_t  st;
  srec_pkg::parse_state_t  st_next;
  logic                    res_valid;
  srec_pkg::parse_result_t res;
  logic [31:0]             addr_sum;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign addr_sum  = dest_base + res.offset;

  srec_step u_step (
    .st        (st),
    .ch        (s1_char),
    .st_next   (st_next),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_base <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      dest_base <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char <= in_char;
    end
  end

  // parser state moves when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_kind <= res.kind;
      wr_data  <= res.data;
      wr_addr  <= (res.kind == srec_pkg::KIND_DATA) ? addr_sum[ADDR_WIDTH-1:0]
                                                    : '0;
    end
  end

  `SREC_ASSERT_NEXT(a_done_sticks, st.done, st.done, "done flag dropped before reset")
  `SREC_ASSERT_NEXT(a_report_sets_done,
    s1_adv && res_valid && res.kind != srec_pkg::KIND_DATA, st.done,
    "report item without done flag")
  `SREC_ASSERT_IMPL(a_data_from_data_phase,
    s1_adv && res_valid && res.kind == srec_pkg::KIND_DATA, st.phase == srec_pkg::PH_DATA,
    "data write outside data phase")
  `SREC_ASSERT_IMPL(a_data_digit_range, st.phase == srec_pkg::PH_DATA, st.digit_pos <= 4'd1,
    "data digit position out of range")
  `SREC_ASSERT_NEXT(a_no_result_after_done, st.done && s1_adv, !out_valid,
    "result produced after done")

endmodule

// ----- verif/srec_load_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srec loader result checker
// watches the char, result and base-write channels of the loader core, keeps
// its own parser state to work out the write each char item causes, and
// compares every result item with the oldest expected write in order
// ----------------------------------------------------------------------------
module srec_load_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [31:0] wr_addr,
  input  logic [7:0]  wr_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [7:0]  data;
  } load_item_t;

  load_item_t  write_q[$];

  logic [31:0] base_m;
  logic [2:0]  phase_m;
  logic [7:0]  count_m;
  logic [31:0] raddr_m;
  logic [3:0]  hold_m;
  logic [3:0]  digit_m;
  logic [7:0]  idx_m;
  logic        done_m;

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = c - srec_pkg::CH_ZERO;
    if (v > 8'd9) begin
      v = v - srec_pkg::HEX_GAP;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] payload_len();
    return (count_m >= srec_pkg::HDR_BYTES) ? count_m - srec_pkg::HDR_BYTES : 8'd0;
  endfunction

  // advances the parser by one char, returns 1 when a result item is due
  function automatic bit parse_char(input logic [7:0] c, output load_item_t r);
    logic [3:0] nib;
    r = '0;
    if (done_m) begin
      return 1'b0;
    end
    if (phase_m == srec_pkg::PH_START) begin
      if (c != srec_pkg::CH_S) begin
        done_m = 1'b1;
        r.kind = srec_pkg::KIND_STOPPED;
        return 1'b1;
      end
      phase_m = srec_pkg::PH_TYPE;
      return 1'b0;
    end
    if (c == srec_pkg::CH_LF) begin
      phase_m = srec_pkg::PH_START;
      digit_m = 4'd0;
      return 1'b0;
    end
    nib = digit_value(c);
    case (phase_m)
      srec_pkg::PH_TYPE: begin
        if (c == srec_pkg::CH_SEVEN || c == srec_pkg::CH_EIGHT ||
            c == srec_pkg::CH_NINE) begin
          done_m = 1'b1;
          r.kind = srec_pkg::KIND_FINISHED;
          return 1'b1;
        end
        if (c == srec_pkg::CH_THREE) begin
          phase_m = srec_pkg::PH_COUNT;
          digit_m = 4'd0;
          count_m = 8'd0;
          raddr_m = 32'd0;
          idx_m   = 8'd0;
        end else begin
          phase_m = srec_pkg::PH_SKIP;
        end
      end
      srec_pkg::PH_COUNT: begin
        count_m = {count_m[3:0], nib};
        digit_m = digit_m + 4'd1;
        if (digit_m >= 4'd2) begin
          digit_m = 4'd0;
          phase_m = srec_pkg::PH_ADDR;
        end
      end
      srec_pkg::PH_ADDR: begin
        raddr_m = {raddr_m[27:0], nib};
        digit_m = digit_m + 4'd1;
        if (digit_m >= 4'd8) begin
          digit_m = 4'd0;
          idx_m   = 8'd0;
          phase_m = (payload_len() == 8'd0) ? srec_pkg::PH_SKIP : srec_pkg::PH_DATA;
        end
      end
      srec_pkg::PH_DATA: begin
        if (digit_m == 4'd0) begin
          hold_m  = nib;
          digit_m = 4'd1;
        end else begin
          r.kind  = srec_pkg::KIND_DATA;
          r.addr  = base_m + raddr_m + {24'd0, idx_m};
          r.data  = {hold_m, nib};
          digit_m = 4'd0;
          idx_m   = idx_m + 8'd1;
          if (idx_m >= payload_len()) begin
            phase_m = srec_pkg::PH_SKIP;
          end
          return 1'b1;
        end
      end
      default: begin
        phase_m = srec_pkg::PH_SKIP;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic flag(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin : watch
    load_item_t want;
    load_item_t next_w;
    if (rst) begin
      base_m     = 32'd0;
      phase_m    = srec_pkg::PH_START;
      count_m    = 8'd0;
      raddr_m    = 32'd0;
      hold_m     = 4'd0;
      digit_m    = 4'd0;
      idx_m      = 8'd0;
      done_m     = 1'b0;
      fail_count = 0;
      write_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        base_m = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (write_q.size() == 0) begin
          flag($sformatf("unexpected result item: kind %0d addr %h data %h",
                         out_kind, wr_addr, wr_data));
        end else begin
          want = write_q.pop_front();
          if (out_kind !== want.kind || wr_addr !== want.addr || wr_data !== want.data) begin
            flag($sformatf("result mismatch: kind %0d/%0d addr %h/%h data %h/%h (exp/got)",
                           want.kind, out_kind, want.addr, wr_addr, want.data, wr_data));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (parse_char(in_char, next_w)) begin
          write_q.push_back(next_w);
        end
      end
    end
    pending = write_q.size();
  end

endmodule

// ----- verif/tb_srec_s3_record_loader_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srec s3 record loader core testbench
// feeds s-record text one char item at a time with random gaps and result
// stalls, changes the base address between phases, and ends on one end
// record or bad line start; the checker does all prediction and comparison
// ----------------------------------------------------------------------------
module tb_srec_s3_record_loader_core;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam int         PHASES     = 8;
  localparam int         PHASE_LEN  = 200;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_char   = 8'd0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = 32'd0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [31:0] wr_addr;
  logic [7:0]  wr_data;
  logic        cfg_ready;

  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  int          chars_sent = 0;
  logic [7:0]  line_q[$];

  srec_s3_record_loader_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_char   (in_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  srec_load_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char    (in_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [7:0] rand_non_lf();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == srec_pkg::CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] letter;
    letter = ($urandom_range(0, 1) != 0) ? CH_LOWER_A : CH_UPPER_A;
    if (nib < 4'd10) begin
      return srec_pkg::CH_ZERO + {4'd0, nib};
    end
    return letter + {4'd0, nib} - 8'd10;
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2:       return 32'h7FFF_FFF0 + $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_char(input logic [7:0] c);
    int   gap;
    logic stalled;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[k]) begin
      push_char(line_q[k]);
    end
    line_q.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    line_q.push_back(hex_char(b[7:4]));
    line_q.push_back(hex_char(b[3:0]));
  endtask

  task automatic build_s3(input int ndata, input logic [7:0] count, input logic [31:0] addr);
    line_q.push_back(srec_pkg::CH_S);
    line_q.push_back(srec_pkg::CH_THREE);
    add_byte(count);
    for (int k = 3; k >= 0; k--) begin
      add_byte(addr[k*8 +: 8]);
    end
    for (int k = 0; k < ndata; k++) begin
      add_byte(8'($urandom_range(0, 255)));
    end
    add_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      line_q.push_back(CH_CR);
    end
    line_q.push_back(srec_pkg::CH_LF);
  endtask

  task automatic random_line();
    int         sel;
    int         n;
    int         keep;
    logic [7:0] rtype;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      n = ($urandom_range(0, 39) == 0) ? $urandom_range(20, 250) : $urandom_range(1, 12);
      if (sel < 60) begin
        // count sometimes shorter than the data given
        build_s3(n, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(5, n + 4)) : 8'(n + 5),
                 pick_addr());
        if ($urandom_range(0, 9) == 0) begin
          line_q[$urandom_range(2, line_q.size() - 2)] = rand_non_lf();
        end
      end else begin
        // line cut short at some point after the type
        build_s3(n, 8'(n + 5), pick_addr());
        keep = $urandom_range(2, line_q.size() - 2);
        while (line_q.size() > keep) begin
          void'(line_q.pop_back());
        end
        line_q.push_back(srec_pkg::CH_LF);
      end
    end else if (sel < 76) begin
      build_s3($urandom_range(0, 3), 8'($urandom_range(0, 4)), pick_addr());
    end else if (sel < 80) begin
      line_q.push_back(srec_pkg::CH_S);
      line_q.push_back(srec_pkg::CH_LF);
    end else begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       rtype = srec_pkg::CH_ZERO;
          1:       rtype = srec_pkg::CH_ZERO + 8'd1;
          2:       rtype = srec_pkg::CH_ZERO + 8'd2;
          3:       rtype = srec_pkg::CH_ZERO + 8'd4;
          4:       rtype = srec_pkg::CH_ZERO + 8'd5;
          default: rtype = srec_pkg::CH_ZERO + 8'd6;
        endcase
      end else begin
        do begin
          rtype = rand_non_lf();
        end while (rtype == srec_pkg::CH_THREE || rtype == srec_pkg::CH_SEVEN ||
                   rtype == srec_pkg::CH_EIGHT || rtype == srec_pkg::CH_NINE);
      end
      line_q.push_back(srec_pkg::CH_S);
      line_q.push_back(rtype);
      repeat ($urandom_range(0, 12)) line_q.push_back(rand_non_lf());
      line_q.push_back(srec_pkg::CH_LF);
    end
    send_line();
  endtask

  // drop valid, wait out every expected item plus the pipeline
  task automatic settle();
    int left;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      left = pending;
      @(posedge clk);
    end while (left != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_base(input logic [31:0] v);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
  endtask

  initial begin : drain_side
    int   n;
    logic seen;
    @(posedge clk);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        seen = out_valid;
        @(posedge clk);
      end while (!seen);
    end
  end

  initial begin : feed_side
    logic [31:0] base;
    logic [7:0]  c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // s3 at the top address with extreme data, wraps past zero
    line_q.push_back(srec_pkg::CH_S);
    line_q.push_back(srec_pkg::CH_THREE);
    add_byte(8'h07);
    repeat (4) add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hFF);
    line_q.push_back(srec_pkg::CH_LF);
    // small count, then line feed straight after s
    line_q.push_back(srec_pkg::CH_S);
    line_q.push_back(srec_pkg::CH_THREE);
    add_byte(8'h03);
    line_q.push_back(srec_pkg::CH_LF);
    line_q.push_back(srec_pkg::CH_S);
    line_q.push_back(srec_pkg::CH_LF);
    // skipped record with top-bit chars
    line_q.push_back(srec_pkg::CH_S);
    line_q.push_back(srec_pkg::CH_ZERO + 8'd5);
    line_q.push_back(8'hFF);
    line_q.push_back(8'h80);
    line_q.push_back(srec_pkg::CH_LF);
    send_line();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       base = 32'hFFFF_FFFF;
        1:       base = 32'h0000_0000;
        2:       base = 32'h8000_0000;
        3:       base = 32'h0000_0001;
        default: base = $urandom;
      endcase
      load_base(base);
      calm = (p == 2) || ($urandom_range(0, 3) == 0);
      begin : phase_body
        int start;
        start = chars_sent;
        while (chars_sent - start < PHASE_LEN) begin
          random_line();
        end
      end
    end
    calm = 1'b0;

    // one terminal report, since only reset clears it
    case ($urandom_range(0, 2))
      0: begin
        line_q.push_back(srec_pkg::CH_S);
        case ($urandom_range(0, 2))
          0:       line_q.push_back(srec_pkg::CH_SEVEN);
          1:       line_q.push_back(srec_pkg::CH_EIGHT);
          default: line_q.push_back(srec_pkg::CH_NINE);
        endcase
        repeat (6) line_q.push_back(hex_char(4'($urandom_range(0, 15))));
        line_q.push_back(srec_pkg::CH_LF);
      end
      1: begin
        do begin
          c = 8'($urandom_range(0, 255));
        end while (c == srec_pkg::CH_S);
        line_q.push_back(c);
      end
      default: begin
        line_q.push_back(srec_pkg::CH_LF);
      end
    endcase
    send_line();

    // everything after the report must be ignored
    build_s3(4, 8'd9, $urandom);
    repeat (12) line_q.push_back(8'($urandom_range(0, 255)));
    send_line();

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
